// ----- src/ssbd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the seeded substitution byte decoder.
// No dependencies.
package ssbd_pkg;

  localparam int unsigned SEED_MOD    = 250;
  localparam int unsigned SWAP_SPAN   = 254;
  localparam int unsigned STRIDE_BASE = 6;
  localparam int unsigned SEED_SPAN   = SEED_MOD * SWAP_SPAN;
  localparam int unsigned SWAP_COUNT  = 10000;
  localparam int unsigned TABLE_SIZE  = 256;

  // reciprocal multipliers: seed / SEED_SPAN taken as (seed >> 2) * SPAN_RECIP >> SPAN_SHIFT,
  // r / SEED_MOD taken as (r >> 1) * MOD_RECIP >> MOD_SHIFT
  localparam int unsigned SPAN_RECIP  = 554084600;
  localparam int unsigned SPAN_SHIFT  = 43;
  localparam int unsigned MOD_RECIP   = 33555;
  localparam int unsigned MOD_SHIFT   = 22;
  localparam int unsigned DIV_STEPS   = 2;

  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_DIV1  = 4'd2;
  localparam logic [3:0] OP_DIV2  = 4'd3;
  localparam logic [3:0] OP_PREP  = 4'd4;
  localparam logic [3:0] OP_INIT  = 4'd5;
  localparam logic [3:0] OP_SWRD0 = 4'd6;
  localparam logic [3:0] OP_SWRD1 = 4'd7;
  localparam logic [3:0] OP_SWW0  = 4'd8;
  localparam logic [3:0] OP_SWW1  = 4'd9;
  localparam logic [3:0] OP_INV0  = 4'd10;
  localparam logic [3:0] OP_INVRD = 4'd11;
  localparam logic [3:0] OP_INVWR = 4'd12;

  typedef struct packed {
    logic       run;
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic div1_last;
    logic div2_last;
    logic init_last;
    logic swap_last;
    logic inv_last;
  } sts_t;

endpackage

// ----- src/ssbd_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ssbd_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences seed reduction, table build and run mode.
// Depends on ssbd_pkg.
module ssbd_ctrl
  import ssbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_neg,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_RUN   = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_DIV1  = 4'd2;
  localparam logic [3:0] ST_DIV2  = 4'd3;
  localparam logic [3:0] ST_PREP  = 4'd4;
  localparam logic [3:0] ST_INIT  = 4'd5;
  localparam logic [3:0] ST_SWRD0 = 4'd6;
  localparam logic [3:0] ST_SWRD1 = 4'd7;
  localparam logic [3:0] ST_SWW0  = 4'd8;
  localparam logic [3:0] ST_SWW1  = 4'd9;
  localparam logic [3:0] ST_INV0  = 4'd10;
  localparam logic [3:0] ST_INVRD = 4'd11;
  localparam logic [3:0] ST_INVWR = 4'd12;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN:   state_next = ST_RUN;
      ST_LOAD:  state_next = ST_DIV1;
      ST_DIV1:  if (sts.div1_last) begin
                  state_next = ST_DIV2;
                end
      ST_DIV2:  if (sts.div2_last) begin
                  state_next = ST_PREP;
                end
      ST_PREP:  state_next = ST_INIT;
      ST_INIT:  if (sts.init_last) begin
                  state_next = ST_SWRD0;
                end
      ST_SWRD0: state_next = ST_SWRD1;
      ST_SWRD1: state_next = ST_SWW0;
      ST_SWW0:  state_next = ST_SWW1;
      ST_SWW1:  state_next = sts.swap_last ? ST_INV0 : ST_SWRD0;
      ST_INV0:  state_next = ST_INVRD;
      ST_INVRD: state_next = ST_INVWR;
      ST_INVWR: state_next = sts.inv_last ? ST_RUN : ST_INVRD;
      default:  state_next = ST_RUN;
    endcase
    // a seed write from any state restarts the build, or goes straight to run mode for a negative seed
    if (cfg_we) begin
      state_next = cfg_neg ? ST_RUN : ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.run = (state == ST_RUN);
    case (state)
      ST_LOAD:  cmd.op = OP_LOAD;
      ST_DIV1:  cmd.op = OP_DIV1;
      ST_DIV2:  cmd.op = OP_DIV2;
      ST_PREP:  cmd.op = OP_PREP;
      ST_INIT:  cmd.op = OP_INIT;
      ST_SWRD0: cmd.op = OP_SWRD0;
      ST_SWRD1: cmd.op = OP_SWRD1;
      ST_SWW0:  cmd.op = OP_SWW0;
      ST_SWW1:  cmd.op = OP_SWW1;
      ST_INV0:  cmd.op = OP_INV0;
      ST_INVRD: cmd.op = OP_INVRD;
      ST_INVWR: cmd.op = OP_INVWR;
      default:  cmd.op = OP_IDLE;
    endcase
  end

endmodule

// ----- src/ssbd_dp.sv -----
`timescale 1ns / 1ps
// Datapath: seed register, seed reduction, permutation and decode RAMs, stream pipe.
// Depends on ssbd_pkg and ssbd_ram.
module ssbd_dp
  import ssbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata
);

  logic signed [31:0] key_seed;
  logic [13:0] cnt, cnt_next;
  logic [15:0] rem, rem_next;
  logic [15:0] span_quo, span_quo_next;
  logic [7:0]  quo, quo_next;
  logic [7:0]  stride, stride_next;
  logic [7:0]  acc, acc_next;
  logic [7:0]  hold;

  logic [58:0] span_prod;
  logic [30:0] mod_prod;
  logic [8:0]  stride_raw, acc0_raw, acc_step_raw;
  logic [7:0]  stride_red, acc0_red, acc_step_red;
  logic [7:0]  j0, j1, inv_idx;
  logic        cnt_last, cnt_step;

  logic       fwd_we, fwd_re;
  logic [7:0] fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata;
  logic       inv_we;
  logic [7:0] inv_waddr, inv_wdata, inv_rdata;

  logic       accept, move;
  logic       pend_valid, pend_bypass;
  logic [7:0] pend_cipher, pend_offset;
  logic       out_valid;
  logic [7:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_seed <= -32'sd1;
    end else if (cfg_we) begin
      key_seed <= cfg_data;
    end
  end

  // seed reduction and swap index arithmetic
  always_comb begin
    span_prod    = key_seed[30:2] * 30'(SPAN_RECIP);
    mod_prod     = rem[15:1] * 16'(MOD_RECIP);
    stride_raw   = 9'(STRIDE_BASE) + {1'b0, rem[7:0]};
    stride_red   = (stride_raw >= 9'(SWAP_SPAN)) ? 8'(stride_raw - 9'(SWAP_SPAN))
                                                 : stride_raw[7:0];
    acc0_raw     = {1'b0, stride_red} + {1'b0, quo};
    acc0_red     = (acc0_raw >= 9'(SWAP_SPAN)) ? 8'(acc0_raw - 9'(SWAP_SPAN))
                                               : acc0_raw[7:0];
    acc_step_raw = {1'b0, acc} + {1'b0, stride};
    acc_step_red = (acc_step_raw >= 9'(SWAP_SPAN)) ? 8'(acc_step_raw - 9'(SWAP_SPAN))
                                                   : acc_step_raw[7:0];
    j0           = acc + 8'd1;
    j1           = acc + 8'd2;
    inv_idx      = cnt[7:0] + 8'd1;
  end

  always_comb begin
    sts.div1_last = (cnt == 14'(DIV_STEPS - 1));
    sts.div2_last = (cnt == 14'(DIV_STEPS - 1));
    sts.init_last = (cnt == 14'(TABLE_SIZE - 1));
    sts.swap_last = (cnt == 14'(SWAP_COUNT - 1));
    sts.inv_last  = (cnt == 14'(TABLE_SIZE - 2));
  end

  always_comb begin
    rem_next      = rem;
    span_quo_next = span_quo;
    quo_next      = quo;
    stride_next   = stride;
    acc_next      = acc;
    cnt_step      = 1'b0;
    cnt_last      = 1'b0;
    fwd_we        = 1'b0;
    fwd_re        = 1'b0;
    fwd_waddr     = j0;
    fwd_wdata     = fwd_rdata;
    fwd_raddr     = j0;
    inv_we        = 1'b0;
    inv_waddr     = fwd_rdata;
    inv_wdata     = inv_idx;
    case (cmd.op)
      OP_LOAD: begin
        rem_next = '0;
        quo_next = '0;
      end
      OP_DIV1: begin
        // seed mod SEED_SPAN: quotient, then remainder
        if (cnt == 14'd0) begin
          span_quo_next = 16'(span_prod >> SPAN_SHIFT);
        end else begin
          rem_next = key_seed[15:0] - 16'(span_quo * 16'(SEED_SPAN));
        end
        cnt_step = 1'b1;
        cnt_last = sts.div1_last;
      end
      OP_DIV2: begin
        // split into seed mod SEED_MOD and the swap shift
        if (cnt == 14'd0) begin
          quo_next = 8'(mod_prod >> MOD_SHIFT);
        end else begin
          rem_next = {8'd0, rem[7:0] - 8'(quo * 8'(SEED_MOD))};
        end
        cnt_step = 1'b1;
        cnt_last = sts.div2_last;
      end
      OP_PREP: begin
        stride_next = stride_red;
        acc_next    = acc0_red;
      end
      OP_INIT: begin
        fwd_we    = 1'b1;
        fwd_waddr = cnt[7:0];
        fwd_wdata = cnt[7:0];
        cnt_step  = 1'b1;
        cnt_last  = sts.init_last;
      end
      OP_SWRD0: begin
        fwd_re    = 1'b1;
        fwd_raddr = j0;
      end
      OP_SWRD1: begin
        fwd_re    = 1'b1;
        fwd_raddr = j1;
      end
      OP_SWW0: begin
        fwd_we    = 1'b1;
        fwd_waddr = j0;
        fwd_wdata = fwd_rdata;
      end
      OP_SWW1: begin
        fwd_we    = 1'b1;
        fwd_waddr = j1;
        fwd_wdata = hold;
        acc_next  = acc_step_red;
        cnt_step  = 1'b1;
        cnt_last  = sts.swap_last;
      end
      OP_INV0: begin
        inv_we    = 1'b1;
        inv_waddr = '0;
        inv_wdata = '0;
      end
      OP_INVRD: begin
        fwd_re    = 1'b1;
        fwd_raddr = inv_idx;
      end
      OP_INVWR: begin
        inv_we    = 1'b1;
        inv_waddr = fwd_rdata;
        inv_wdata = inv_idx;
        cnt_step  = 1'b1;
        cnt_last  = sts.inv_last;
      end
      default: begin
      end
    endcase
    if (cmd.op == OP_LOAD || (cnt_step && cnt_last)) begin
      cnt_next = '0;
    end else if (cnt_step) begin
      cnt_next = cnt + 14'd1;
    end else begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    span_quo <= span_quo_next;
    quo      <= quo_next;
    stride   <= stride_next;
    acc      <= acc_next;
    if (cmd.op == OP_SWRD1) begin
      hold <= fwd_rdata;
    end
  end

  ssbd_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .re    (fwd_re),
    .raddr (fwd_raddr),
    .rdata (fwd_rdata)
  );

  ssbd_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (inv_waddr),
    .wdata (inv_wdata),
    .re    (accept),
    .raddr (s_axis_tdata[7:0]),
    .rdata (inv_rdata)
  );

  // stream pipe: lookup stage, then output register
  assign move          = pend_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = cmd.run && (!pend_valid || move);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_bypass <= key_seed[31];
      pend_cipher <= s_axis_tdata[7:0];
      pend_offset <= s_axis_tdata[15:8];
    end
    if (move) begin
      out_data <= pend_bypass ? pend_cipher : inv_rdata - pend_offset;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ----- src/seeded_substitution_byte_decoder.sv -----
`timescale 1ns / 1ps
// Seeded substitution byte decoder, top level.
// Depends on ssbd_pkg, ssbd_ctrl, ssbd_dp (and ssbd_ram below it).
//
// Decodes one byte per word: plain = decode[cipher] - offset (mod 256). Writing a
// non-negative seed starts a table build that holds s_axis_tready low while it loads
// and reduces the seed by reciprocal multiplies, makes 256 identity writes, does
// the 10000 swaps (two reads, then two writes each) on the permutation RAM and
// builds the inverse table. A negative seed (the reset value) passes bytes through
// with no build. Once running, a word is taken every cycle unless m_axis_tready
// stalls the output; results go through a RAM lookup stage and an output register.
module seeded_substitution_byte_decoder
  import ssbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] cipher_byte, [15:8] byte_offset
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] plain_byte
  input  logic        cfg_we,
  input  logic [31:0] cfg_data        // key_seed
);

  cmd_t cmd;
  sts_t sts;

  ssbd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_neg (cfg_data[31]),
    .sts     (sts),
    .cmd     (cmd)
  );

  ssbd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
